@@ hw/rtl/bilinear_cell_interpolator_defines.svh @@
// Assertion macros for the verification of the bilinear cell interpolator.
// Needs no other file; included by the port checker.
`ifndef BILINEAR_CELL_INTERPOLATOR_DEFINES_SVH
`define BILINEAR_CELL_INTERPOLATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/bci_pkg.sv @@
// Shared constants, codes and controller/datapath command types of the bilinear
// cell interpolator. Depends on nothing; all RTL files but bci_ram and the header import it.
`timescale 1ns / 1ps

package bci_pkg;

	localparam int BCI_MAX_CHANNELS = 16;
	localparam int BCI_FRAC_BITS    = 16;

	localparam int VAL_W      = 32;
	localparam int CH_W       = 4;
	localparam int CHAN_CNT_W = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Reset value of the reciprocal registers: 1.0 in the default format.
	localparam logic signed [VAL_W-1:0] INV_ONE    = 32'sd65536;
	localparam logic [CHAN_CNT_W-1:0]   CHANS_RST  = 5'd16;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X   = 3'd0,
		REG_ORIGIN_Y   = 3'd1,
		REG_INV_WIDTH  = 3'd2,
		REG_INV_HEIGHT = 3'd3,
		REG_CHANS      = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic load_wr;
		logic query_cap;
		logic norm_mul;
		logic norm_sel_y;
		logic nx_wr;
		logic ny_wr;
		logic issue;
	} bci_cmd_t;

	typedef struct packed {
		logic adv;
		logic pipe_busy;
		logic issue_last;
		logic no_chans;
	} bci_status_t;

endpackage

@@ hw/rtl/bci_intf.sv @@
// Handshake interfaces of the bilinear cell interpolator: input words, result words
// and configuration writes. Depends on bci_pkg.
`timescale 1ns / 1ps

interface bci_item_if;
	import bci_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    op;
	logic [CH_W-1:0]         channel;
	logic signed [VAL_W-1:0] corner_ll;
	logic signed [VAL_W-1:0] corner_lr;
	logic signed [VAL_W-1:0] corner_ul;
	logic signed [VAL_W-1:0] corner_ur;
	logic signed [VAL_W-1:0] query_x;
	logic signed [VAL_W-1:0] query_y;

	modport source (output valid, op, channel, corner_ll, corner_lr, corner_ul, corner_ur,
		query_x, query_y, input ready);
	modport sink (input valid, op, channel, corner_ll, corner_lr, corner_ul, corner_ur,
		query_x, query_y, output ready);
endinterface

interface bci_result_if;
	import bci_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [CH_W-1:0]         out_channel;
	logic signed [VAL_W-1:0] interp_value;
	logic                    last;

	modport source (output valid, out_channel, interp_value, last, input ready);
	modport sink (input valid, out_channel, interp_value, last, output ready);
endinterface

interface bci_cfg_if;
	import bci_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/bci_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the per-channel coefficients.
`timescale 1ns / 1ps

module bci_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/bci_ctrl.sv @@
// Controller of the bilinear cell interpolator: input handshake and the sequence
// load / normalize / issue channels / drain. Depends on bci_pkg.
`timescale 1ns / 1ps

module bci_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_op,
	output logic                 item_ready,
	input  bci_pkg::bci_status_t sts,
	output bci_pkg::bci_cmd_t    cmd
);
	import bci_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_NX    = 6'b000010,
		ST_NY    = 6'b000100,
		ST_NYSAT = 6'b001000,
		ST_RUN   = 6'b010000,
		ST_DRAIN = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (item_op == OP_QUERY) begin
						cmd.query_cap = 1'b1;
						state_d       = ST_NX;
					end else begin
						cmd.load_wr = 1'b1;
					end
				end
			end
			ST_NX: begin
				cmd.norm_mul = 1'b1;
				state_d      = ST_NY;
			end
			ST_NY: begin
				cmd.norm_mul   = 1'b1;
				cmd.norm_sel_y = 1'b1;
				cmd.nx_wr      = 1'b1;
				state_d        = ST_NYSAT;
			end
			ST_NYSAT: begin
				cmd.ny_wr = 1'b1;
				state_d   = sts.no_chans ? ST_IDLE : ST_RUN;
			end
			ST_RUN: begin
				cmd.issue = sts.adv;
				if (sts.adv && sts.issue_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hw/rtl/bci_datapath.sv @@
// Datapath of the bilinear cell interpolator: coefficient store, point normalization
// and the per-channel evaluation pipeline with its output register. Depends on
// bci_pkg and bci_ram.
`timescale 1ns / 1ps

module bci_datapath #(
	parameter int MAX_CHANNELS = bci_pkg::BCI_MAX_CHANNELS,
	parameter int FRAC_BITS    = bci_pkg::BCI_FRAC_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bci_pkg::bci_cmd_t                      cmd,
	output bci_pkg::bci_status_t                   sts,
	input  logic [bci_pkg::CH_W-1:0]               channel,
	input  logic signed [bci_pkg::VAL_W-1:0]       corner_ll,
	input  logic signed [bci_pkg::VAL_W-1:0]       corner_lr,
	input  logic signed [bci_pkg::VAL_W-1:0]       corner_ul,
	input  logic signed [bci_pkg::VAL_W-1:0]       corner_ur,
	input  logic signed [bci_pkg::VAL_W-1:0]       query_x,
	input  logic signed [bci_pkg::VAL_W-1:0]       query_y,
	input  logic signed [bci_pkg::VAL_W-1:0]       origin_x,
	input  logic signed [bci_pkg::VAL_W-1:0]       origin_y,
	input  logic signed [bci_pkg::VAL_W-1:0]       inv_width,
	input  logic signed [bci_pkg::VAL_W-1:0]       inv_height,
	input  logic [bci_pkg::CHAN_CNT_W-1:0]         chans_in_use,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [bci_pkg::CH_W-1:0]               out_channel,
	output logic signed [bci_pkg::VAL_W-1:0]       out_value,
	output logic                                   out_last
);
	import bci_pkg::*;

	localparam int AW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int NW   = $clog2(MAX_CHANNELS + 1);
	localparam int BW   = VAL_W;
	localparam int XSW  = VAL_W + 1;
	localparam int YSW  = VAL_W + 1;
	localparam int CRW  = VAL_W + 2;
	localparam int CW   = BW + XSW + YSW + CRW;
	localparam int DW   = VAL_W + 1;
	localparam int NPW  = VAL_W + DW;
	localparam int CPW  = VAL_W + CRW;
	localparam int YPW  = VAL_W + YSW;
	localparam int TW   = (((CPW - FRAC_BITS) > XSW) ? (CPW - FRAC_BITS) : XSW) + 1;
	localparam int THW  = TW - VAL_W;
	localparam int PLW  = VAL_W + VAL_W + 1;
	localparam int PHW  = VAL_W + THW;
	localparam int PW   = TW + VAL_W + 1;
	localparam int QW   = YPW - FRAC_BITS;
	localparam int RW   = PW - FRAC_BITS;
	localparam int VW   = ((RW > QW) ? RW : QW) + 2;

	function automatic logic signed [VAL_W-1:0] sat_norm(input logic signed [NPW-1:0] v);
		logic signed [NPW-1:0] s;
		s = v >>> FRAC_BITS;
		if ((&s[NPW-1:VAL_W-1]) || !(|s[NPW-1:VAL_W-1])) begin
			return s[VAL_W-1:0];
		end else if (s[NPW-1]) begin
			return {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			return {1'b0, {(VAL_W-1){1'b1}}};
		end
	endfunction

	function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [VW-1:0] v);
		if ((&v[VW-1:VAL_W-1]) || !(|v[VW-1:VAL_W-1])) begin
			return v[VAL_W-1:0];
		end else if (v[VW-1]) begin
			return {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			return {1'b0, {(VAL_W-1){1'b1}}};
		end
	endfunction

	// Coefficient store write side.
	logic signed [BW-1:0]  c_base;
	logic signed [XSW-1:0] c_xs;
	logic signed [YSW-1:0] c_ys;
	logic signed [CRW-1:0] c_cr;
	logic                  ram_we;
	logic [CW-1:0]         ram_rdata;

	assign c_base = corner_ll;
	assign c_xs   = XSW'(corner_lr) - XSW'(corner_ll);
	assign c_ys   = YSW'(corner_ul) - YSW'(corner_ll);
	assign c_cr   = CRW'(corner_ur) - CRW'(corner_lr) - CRW'(corner_ul) + CRW'(corner_ll);
	assign ram_we = cmd.load_wr && (int'(channel) < MAX_CHANNELS);

	// Channel counter and count limit.
	logic [AW-1:0] cnt_q;
	logic [NW-1:0] n_w;

	always_comb begin
		if (int'(chans_in_use) > MAX_CHANNELS) begin
			n_w = NW'(MAX_CHANNELS);
		end else begin
			n_w = NW'(chans_in_use);
		end
	end

	bci_ram #(
		.WIDTH(CW),
		.DEPTH(MAX_CHANNELS)
	) u_coef_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(channel)),
		.wdata({c_base, c_xs, c_ys, c_cr}),
		.re   (cmd.issue),
		.raddr(cnt_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.query_cap) begin
			cnt_q <= '0;
		end else if (cmd.issue) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	// Point normalization over one shared multiplier.
	logic signed [DW-1:0]    dx_q;
	logic signed [DW-1:0]    dy_q;
	logic signed [VAL_W-1:0] mul_a;
	logic signed [DW-1:0]    mul_b;
	logic signed [NPW-1:0]   norm_prod;
	logic signed [NPW-1:0]   prod_q;
	logic signed [VAL_W-1:0] nx_q;
	logic signed [VAL_W-1:0] ny_q;

	assign mul_a     = cmd.norm_sel_y ? inv_height : inv_width;
	assign mul_b     = cmd.norm_sel_y ? dy_q : dx_q;
	assign norm_prod = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.query_cap) begin
			dx_q <= DW'(query_x) - DW'(origin_x);
			dy_q <= DW'(query_y) - DW'(origin_y);
		end
		if (cmd.norm_mul) begin
			prod_q <= norm_prod;
		end
		if (cmd.nx_wr) begin
			nx_q <= sat_norm(prod_q);
		end
		if (cmd.ny_wr) begin
			ny_q <= sat_norm(prod_q);
		end
	end

	// Channel pipeline. Stage 1 holds the RAM read; all stages move together.
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic out_valid_q;

	logic [AW-1:0] ch_s1, ch_s2, ch_s3, ch_s4, ch_s5, out_ch_q;
	logic          last_s1, last_s2, last_s3, last_s4, last_s5, out_last_q;

	logic signed [BW-1:0]  r_base;
	logic signed [XSW-1:0] r_xs;
	logic signed [YSW-1:0] r_ys;
	logic signed [CRW-1:0] r_cr;

	logic signed [CPW-1:0] crp_s2;
	logic signed [YPW-1:0] ysp_s2;
	logic signed [BW-1:0]  base_s2, base_s3, base_s4, base_s5;
	logic signed [XSW-1:0] xs_s2;
	logic signed [TW-1:0]  t_s3;
	logic signed [QW-1:0]  q_s3, q_s4, q_s5;
	logic signed [PLW-1:0] pl_s4;
	logic signed [PHW-1:0] ph_s4;
	logic signed [PW-1:0]  prod_s5;
	logic signed [VW-1:0]  vsum;
	logic signed [VAL_W-1:0] out_value_q;

	logic signed [CPW-1:0] crp_w;
	logic signed [YPW-1:0] ysp_w;
	logic signed [TW-1:0]  t_w;
	logic signed [PLW-1:0] pl_w;
	logic signed [PHW-1:0] ph_w;
	logic signed [PW-1:0]  prod_w;

	assign r_cr   = ram_rdata[CRW-1:0];
	assign r_ys   = ram_rdata[CRW +: YSW];
	assign r_xs   = ram_rdata[CRW+YSW +: XSW];
	assign r_base = ram_rdata[CRW+YSW+XSW +: BW];

	assign adv = !out_valid_q || out_ready;

	assign crp_w  = ny_q * r_cr;
	assign ysp_w  = ny_q * r_ys;
	assign t_w    = TW'(xs_s2) + TW'(crp_s2 >>> FRAC_BITS);
	assign pl_w   = nx_q * $signed({1'b0, t_s3[VAL_W-1:0]});
	assign ph_w   = nx_q * $signed(t_s3[TW-1:VAL_W]);
	assign prod_w = (PW'(ph_s4) <<< VAL_W) + PW'(pl_s4);
	assign vsum   = VW'(base_s5) + VW'(prod_s5 >>> FRAC_BITS) + VW'(q_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= cmd.issue;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s1       <= cnt_q;
			last_s1     <= sts.issue_last;
			ch_s2       <= ch_s1;
			last_s2     <= last_s1;
			crp_s2      <= crp_w;
			ysp_s2      <= ysp_w;
			base_s2     <= r_base;
			xs_s2       <= r_xs;
			ch_s3       <= ch_s2;
			last_s3     <= last_s2;
			t_s3        <= t_w;
			q_s3        <= QW'(ysp_s2 >>> FRAC_BITS);
			base_s3     <= base_s2;
			ch_s4       <= ch_s3;
			last_s4     <= last_s3;
			pl_s4       <= pl_w;
			ph_s4       <= ph_w;
			q_s4        <= q_s3;
			base_s4     <= base_s3;
			ch_s5       <= ch_s4;
			last_s5     <= last_s4;
			prod_s5     <= prod_w;
			q_s5        <= q_s4;
			base_s5     <= base_s4;
			out_ch_q    <= ch_s5;
			out_last_q  <= last_s5;
			out_value_q <= sat_val(vsum);
		end
	end

	assign sts.adv        = adv;
	assign sts.pipe_busy  = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	assign sts.issue_last = ((NW'(cnt_q) + NW'(1)) == n_w);
	assign sts.no_chans   = (n_w == '0);

	assign out_valid   = out_valid_q;
	assign out_channel = CH_W'(out_ch_q);
	assign out_value   = out_value_q;
	assign out_last    = out_last_q;

endmodule

@@ hw/rtl/bilinear_cell_interpolator.sv @@
// Bilinear cell interpolator. A load word (op 0) stores one channel's four corner
// values as coefficients in a single coefficient RAM; results do not come from
// loads. A query word (op 1) is accepted, goes through point normalization on one
// shared multiplier (x, then y, then the y saturation), and then reads one channel
// per cycle from the coefficient RAM's single read port while the sink does not
// stall, so a query keeps the input blocked while its channels are issued and until
// the five-stage evaluation pipeline has drained, because the normalized point is
// shared by all of its channels. Results appear in channel order, one per cycle
// while the sink is ready, and the final one of a query has last set. A finished
// result waits in the output register while the block already accepts the next
// word; a stalled sink freezes the whole evaluation pipeline. Configuration writes
// are always accepted and must only be issued while no query is in progress. Values
// are signed fixed point with FRAC_BITS fraction bits; the normalized coordinates
// and the results saturate to 32 bits, and every intermediate product is kept at
// full width. A query of a channel that was never loaded returns an undefined value.
`timescale 1ns / 1ps

module bilinear_cell_interpolator #(
	parameter int MAX_CHANNELS = bci_pkg::BCI_MAX_CHANNELS,
	parameter int FRAC_BITS    = bci_pkg::BCI_FRAC_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	bci_item_if.sink      item,
	bci_result_if.source  result,
	bci_cfg_if.sink       cfg
);
	import bci_pkg::*;

	// Configuration registers. The port never stalls; a write to an index past the
	// last register is dropped. The reciprocals reset to 1.0 in the configured format.
	logic signed [VAL_W-1:0] origin_x_q;
	logic signed [VAL_W-1:0] origin_y_q;
	logic signed [VAL_W-1:0] inv_width_q;
	logic signed [VAL_W-1:0] inv_height_q;
	logic [CHAN_CNT_W-1:0]   chans_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			inv_width_q  <= VAL_W'(1) << FRAC_BITS;
			inv_height_q <= VAL_W'(1) << FRAC_BITS;
			chans_q      <= CHANS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ORIGIN_X:   origin_x_q   <= $signed(cfg.data[VAL_W-1:0]);
				REG_ORIGIN_Y:   origin_y_q   <= $signed(cfg.data[VAL_W-1:0]);
				REG_INV_WIDTH:  inv_width_q  <= $signed(cfg.data[VAL_W-1:0]);
				REG_INV_HEIGHT: inv_height_q <= $signed(cfg.data[VAL_W-1:0]);
				REG_CHANS:      chans_q      <= cfg.data[CHAN_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// The controller sequences each word; the datapath does the arithmetic and
	// reports back pipeline progress and the end of the channel sweep.
	bci_cmd_t    cmd;
	bci_status_t sts;

	bci_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item.valid),
		.item_op   (item.op),
		.item_ready(item.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bci_datapath #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.FRAC_BITS   (FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.channel     (item.channel),
		.corner_ll   (item.corner_ll),
		.corner_lr   (item.corner_lr),
		.corner_ul   (item.corner_ul),
		.corner_ur   (item.corner_ur),
		.query_x     (item.query_x),
		.query_y     (item.query_y),
		.origin_x    (origin_x_q),
		.origin_y    (origin_y_q),
		.inv_width   (inv_width_q),
		.inv_height  (inv_height_q),
		.chans_in_use(chans_q),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.out_channel (result.out_channel),
		.out_value   (result.interp_value),
		.out_last    (result.last)
	);

endmodule

@@ hw/rtl/bci_checker.sv @@
// Port-level checker of the bilinear cell interpolator and its bind to the top level.
// Depends on bci_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "bilinear_cell_interpolator_defines.svh"

module bci_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            item_valid,
	input logic                            item_ready,
	input logic                            item_op,
	input logic                            result_valid,
	input logic                            result_ready,
	input logic [bci_pkg::CH_W-1:0]        result_channel,
	input logic signed [bci_pkg::VAL_W-1:0] result_value,
	input logic                            result_last
);
	import bci_pkg::*;

	logic item_acc;
	logic res_stall;

	assign item_acc  = item_valid && item_ready;
	assign res_stall = result_valid && !result_ready;

	// A stalled result word stays offered and unchanged.
	`BCI_ASSERT_NEXT(a_res_hold, clk, arst_n, res_stall, result_valid,
		"result dropped while stalled")
	`BCI_ASSERT_NEXT(a_res_stable, clk, arst_n, res_stall,
		$stable(result_value) && $stable(result_channel) && $stable(result_last),
		"result changed while stalled")

	// A query occupies the block: the input is closed right after it.
	`BCI_ASSERT_NEXT(a_query_busy, clk, arst_n, item_acc && (item_op == OP_QUERY),
		!item_ready, "input open right after a query")

	// A load never produces a result word of its own.
	`BCI_ASSERT_NEXT(a_load_silent, clk, arst_n,
		item_acc && (item_op == OP_LOAD) && !result_valid, !result_valid,
		"result raised by a load")

endmodule

bind bilinear_cell_interpolator bci_checker u_bci_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item.valid),
	.item_ready    (item.ready),
	.item_op       (item.op),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.result_channel(result.out_channel),
	.result_value  (result.interp_value),
	.result_last   (result.last)
);

@@ bench/bilinear_cell_interpolator_test.sv @@
// Self-checking testbench of the bilinear cell interpolator: random and directed words,
// exact Q16.16 prediction in a scoreboard class. Depends on bci_pkg, bci_intf and the RTL.
`timescale 1ns / 1ps

module bilinear_cell_interpolator_test;
	import bci_pkg::*;

	// Longest stretch without any handshake before the run is declared hung. The slowest
	// correct stretch is a 16-channel query behind a slow sink plus the idle settle.
	localparam int STALL_LIMIT  = 2000;
	// Cycles left after the last result before a register write or the end of the run.
	localparam int QUIET_CYCLES = 40;
	localparam int REPORT_MAX   = 10;
	localparam int Q_ONE        = 65536;

	localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh80000000;
	localparam longint PRODUCT_LIMIT = longint'(1) <<< 62;
	// Index past the last register; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] SPARE_REG_IDX = 3'd7;

	typedef struct {
		op_t                     op;
		logic [CH_W-1:0]         channel;
		logic signed [VAL_W-1:0] ll;
		logic signed [VAL_W-1:0] lr;
		logic signed [VAL_W-1:0] ul;
		logic signed [VAL_W-1:0] ur;
		logic signed [VAL_W-1:0] qx;
		logic signed [VAL_W-1:0] qy;
	} interp_word_t;

	typedef struct {
		logic [CH_W-1:0]         chan;
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} interp_result_t;

	// Scoreboard: keeps its own copy of the registers and the per-channel coefficients,
	// computes the values each query must produce and checks results in arrival order.
	class interp_checker;
		longint origin_x, origin_y, inv_w, inv_h;
		logic [CHAN_CNT_W-1:0] chans;
		longint base_c[BCI_MAX_CHANNELS];
		longint x_slope[BCI_MAX_CHANNELS];
		longint y_slope[BCI_MAX_CHANNELS];
		longint cross_term[BCI_MAX_CHANNELS];
		bit loaded[BCI_MAX_CHANNELS];
		interp_result_t pending_values[$];
		int mismatches, strays, reports, checked, loads, queries;

		function new();
			origin_x = 0;
			origin_y = 0;
			inv_w = INV_ONE;
			inv_h = INV_ONE;
			chans = CHANS_RST;
			for (int i = 0; i < BCI_MAX_CHANNELS; i++) begin
				loaded[i] = 1'b0;
			end
		endfunction

		// Exact product, shifted down with a floor and clamped to +-2^62.
		function longint scaled_product(longint a, longint b);
			logic signed [127:0] wide_a, wide_b, prod, lim;
			wide_a = a;
			wide_b = b;
			lim = PRODUCT_LIMIT;
			prod = (wide_a * wide_b) >>> BCI_FRAC_BITS;
			if (prod > lim)
				return PRODUCT_LIMIT;
			if (prod < -lim)
				return -PRODUCT_LIMIT;
			return longint'(prod);
		endfunction

		function longint clamp32(longint v);
			if (v > longint'(Q_MAX))
				return longint'(Q_MAX);
			if (v < longint'(Q_MIN))
				return longint'(Q_MIN);
			return v;
		endfunction

		function int active_channels();
			return (chans > BCI_MAX_CHANNELS) ? BCI_MAX_CHANNELS : int'(chans);
		endfunction

		function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_ORIGIN_X:   origin_x = longint'($signed(data));
				REG_ORIGIN_Y:   origin_y = longint'($signed(data));
				REG_INV_WIDTH:  inv_w = longint'($signed(data));
				REG_INV_HEIGHT: inv_h = longint'($signed(data));
				REG_CHANS:      chans = data[CHAN_CNT_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_word(interp_word_t w);
			interp_result_t r;
			longint nx, ny, t, v;
			int n;
			if (w.op == OP_LOAD) begin
				loads++;
				base_c[w.channel] = longint'(w.ll);
				x_slope[w.channel] = longint'(w.lr) - longint'(w.ll);
				y_slope[w.channel] = longint'(w.ul) - longint'(w.ll);
				cross_term[w.channel] = longint'(w.ur) - longint'(w.lr) - longint'(w.ul)
					+ longint'(w.ll);
				loaded[w.channel] = 1'b1;
			end else begin
				queries++;
				nx = clamp32(scaled_product(inv_w, longint'(w.qx) - origin_x));
				ny = clamp32(scaled_product(inv_h, longint'(w.qy) - origin_y));
				n = active_channels();
				for (int i = 0; i < n; i++) begin
					t = x_slope[i] + scaled_product(ny, cross_term[i]);
					v = base_c[i] + scaled_product(nx, t) + scaled_product(ny, y_slope[i]);
					r.chan = i[CH_W-1:0];
					r.value = VAL_W'(clamp32(v));
					r.last = (i == n - 1);
					pending_values.push_back(r);
				end
			end
		endfunction

		function void check_result(logic [CH_W-1:0] chan, logic signed [VAL_W-1:0] value,
				logic last);
			interp_result_t e;
			if (pending_values.size() == 0) begin
				strays++;
				reports++;
				if (reports <= REPORT_MAX)
					$display("%0t: result with nothing pending: channel %0d value %0d last %b",
						$realtime, chan, value, last);
				return;
			end
			e = pending_values.pop_front();
			checked++;
			if (chan !== e.chan || value !== e.value || last !== e.last) begin
				mismatches++;
				reports++;
				if (reports <= REPORT_MAX)
					$display("%0t: mismatch: channel exp %0d got %0d, value exp %0d got %0d, %s%b got %b",
						$realtime, e.chan, chan, e.value, value, "last exp ", e.last, last);
			end
		endfunction

		// True when every channel a query would read has been loaded.
		function bit ready_for_query();
			for (int i = 0; i < active_channels(); i++) begin
				if (!loaded[i])
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function int outstanding();
			return pending_values.size();
		endfunction

		function int failures();
			return mismatches + strays + pending_values.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	bci_item_if   item_bus ();
	bci_result_if result_bus ();
	bci_cfg_if    cfg_bus ();

	bilinear_cell_interpolator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	interp_checker checker_h;

	// Sender pacing: words go out in bursts; a burst length of zero means a gap is due.
	int burst_left;
	bit hold_done;
	int settings_used;
	// Geometry of the current cell, used to aim most random query points inside it.
	int cell_ox, cell_oy, span_x, span_y;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Every result word is checked at the edge where it is taken.
	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready)
			checker_h.check_result(result_bus.out_channel, result_bus.interp_value,
				result_bus.last);
	end

	// The sink stalls on a pattern of its own: segments of random length that are either
	// always ready, coin-flip ready, ready one cycle in four, or ready one cycle in nineteen.
	initial begin : sink_pacing
		int mode, seg_left, beat;
		result_bus.ready = 1'b0;
		seg_left = 0;
		mode = 0;
		beat = 0;
		forever begin
			@(negedge clk);
			if (seg_left == 0) begin
				mode = $urandom_range(0, 3);
				seg_left = $urandom_range(16, 160);
				beat = 0;
			end
			seg_left--;
			beat++;
			case (mode)
				0: result_bus.ready <= 1'b1;
				1: result_bus.ready <= $urandom_range(0, 1);
				2: result_bus.ready <= (beat % 4 == 0);
				default: result_bus.ready <= (beat % 19 == 0);
			endcase
		end
	end

	// Ends the run when no word of any channel has moved for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)
					|| (cfg_bus.valid && cfg_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no handshake for %0d cycles, %0d results still pending.",
			STALL_LIMIT, checker_h.outstanding());
		$display("*** FAILED ***");
		$finish;
	end

	// Signed Q16.16 value drawn from a mix: half small and moderate magnitudes, some
	// extremes, and some raw 32-bit patterns so that every bit toggles.
	function automatic logic [VAL_W-1:0] rand_q();
		case ($urandom_range(0, 9))
			0, 1, 2: return int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
			3, 4:    return int'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
			5: begin
				case ($urandom_range(0, 5))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return 32'hffff_ffff;
					3: return 32'h0000_0001;
					4: return 32'h8000_0001;
					default: return 32'h7fff_fffe;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	function automatic interp_word_t make_load(logic [CH_W-1:0] ch, logic [VAL_W-1:0] ll,
			logic [VAL_W-1:0] lr, logic [VAL_W-1:0] ul, logic [VAL_W-1:0] ur);
		interp_word_t w;
		w.op = OP_LOAD;
		w.channel = ch;
		w.ll = ll;
		w.lr = lr;
		w.ul = ul;
		w.ur = ur;
		// The query point of a load word is don't-care, so it carries noise.
		w.qx = $urandom();
		w.qy = $urandom();
		return w;
	endfunction

	function automatic interp_word_t make_query(logic [VAL_W-1:0] x, logic [VAL_W-1:0] y);
		interp_word_t w;
		w.op = OP_QUERY;
		w.channel = $urandom_range(0, BCI_MAX_CHANNELS - 1);
		w.ll = $urandom();
		w.lr = $urandom();
		w.ul = $urandom();
		w.ur = $urandom();
		w.qx = x;
		w.qy = y;
		return w;
	endfunction

	// Most points fall in or just around the current cell; the rest are anywhere.
	function automatic logic [VAL_W-1:0] pick_coord(int origin, int span);
		if ($urandom_range(0, 9) < 7)
			return origin + int'($urandom_range(0, span + span / 2)) - span / 4;
		return rand_q();
	endfunction

	// Reciprocal of a cell size, both in Q16.16.
	function automatic logic [VAL_W-1:0] inv_of(int span);
		return VAL_W'((longint'(1) <<< 32) / span);
	endfunction

	// Sends one word, waits for its handshake, then applies the burst and gap pacing.
	// Now and then, and at least once, the sender also holds off until every pending
	// result has arrived.
	task automatic push_word(input interp_word_t w);
		int gap;
		bit hold;
		@(negedge clk);
		item_bus.valid <= 1'b1;
		item_bus.op <= w.op;
		item_bus.channel <= w.channel;
		item_bus.corner_ll <= w.ll;
		item_bus.corner_lr <= w.lr;
		item_bus.corner_ul <= w.ul;
		item_bus.corner_ur <= w.ur;
		item_bus.query_x <= w.qx;
		item_bus.query_y <= w.qy;
		do
			@(posedge clk);
		while (!item_bus.ready);
		checker_h.note_word(w);

		gap = 0;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 20);
		end
		hold = (!hold_done && checker_h.loads + checker_h.queries >= 60)
			|| ($urandom_range(0, 39) == 0);
		if (hold)
			hold_done = 1'b1;
		if (hold || gap > 0) begin
			@(negedge clk);
			item_bus.valid <= 1'b0;
			if (gap > 1)
				repeat (gap - 1) @(negedge clk);
			if (hold)
				while (checker_h.outstanding() != 0) @(negedge clk);
		end
	endtask

	// Brings the block to rest: input idle, all results in, pipeline drained.
	task automatic settle();
		@(negedge clk);
		item_bus.valid <= 1'b0;
		while (checker_h.outstanding() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// Leaves valid high so back-to-back writes need only one assignment per edge.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= data;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		checker_h.note_config(idx, data);
	endtask

	// Writes a full register setting while the block is idle. The channel count goes out
	// with noise in the unused upper data bits, and the spare index gets a junk write.
	task automatic configure(input logic [VAL_W-1:0] ox, input logic [VAL_W-1:0] oy,
			input logic [VAL_W-1:0] iw, input logic [VAL_W-1:0] ih, input int chans,
			input int sx, input int sy);
		logic [CFG_DATA_W-1:0] chan_word;
		settle();
		chan_word = $urandom();
		chan_word[CHAN_CNT_W-1:0] = chans[CHAN_CNT_W-1:0];
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_INV_WIDTH, iw);
		write_reg(REG_INV_HEIGHT, ih);
		write_reg(REG_CHANS, chan_word);
		write_reg(SPARE_REG_IDX, $urandom());
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
		cell_ox = ox;
		cell_oy = oy;
		span_x = sx;
		span_y = sy;
		settings_used++;
	endtask

	// Random mix: about a third loads with random corners, the rest queries.
	task automatic run_random(input int count);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 9) < 3 || !checker_h.ready_for_query())
				push_word(make_load($urandom_range(0, BCI_MAX_CHANNELS - 1), rand_q(), rand_q(),
					rand_q(), rand_q()));
			else
				push_word(make_query(pick_coord(cell_ox, span_x), pick_coord(cell_oy, span_y)));
		end
	endtask

	// Directed part under the reset setting (unit cell at the origin, all 16 channels):
	// every channel is loaded first so no query ever reads an unwritten entry, some with
	// flat, all-maximum, all-minimum and opposing extreme corners, then queries hit two
	// opposite corners, the center, the extremes of the point range and small negative
	// offsets that exercise the floor of the shifts, and finally a reload is read back at once.
	task automatic run_directed();
		for (int ch = 0; ch < BCI_MAX_CHANNELS; ch++) begin
			case (ch)
				0: push_word(make_load(ch, 0, 0, 0, 0));
				1: push_word(make_load(ch, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
				2: push_word(make_load(ch, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
				3: push_word(make_load(ch, Q_MIN, Q_MAX, Q_MAX, Q_MIN));
				4: push_word(make_load(ch, Q_MAX, Q_MIN, Q_MIN, Q_MAX));
				5: push_word(make_load(ch, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 4 * Q_ONE));
				default: push_word(make_load(ch, rand_q(), rand_q(), rand_q(), rand_q()));
			endcase
		end
		push_word(make_query(0, 0));
		push_word(make_query(Q_ONE, Q_ONE));
		push_word(make_query(Q_ONE / 2, Q_ONE / 2));
		push_word(make_query(Q_MAX, Q_MAX));
		push_word(make_query(Q_MIN, Q_MIN));
		push_word(make_query(Q_MAX, Q_MIN));
		push_word(make_query(Q_MIN, Q_MAX));
		push_word(make_query(-1, -1));
		push_word(make_load(0, -Q_ONE, Q_ONE, -Q_ONE, Q_ONE));
		push_word(make_query(Q_ONE / 4, 3 * Q_ONE / 4));
	endtask

	initial begin
		int chans, sx, sy;
		logic [VAL_W-1:0] iw;

		checker_h = new();
		burst_left = 0;
		hold_done = 1'b0;
		settings_used = 0;
		cell_ox = 0;
		cell_oy = 0;
		span_x = Q_ONE;
		span_y = Q_ONE;

		// Every input is known from time zero; reset is applied once, at the start of the run.
		arst_n = 1'b0;
		item_bus.valid = 1'b0;
		item_bus.op = OP_LOAD;
		item_bus.channel = '0;
		item_bus.corner_ll = '0;
		item_bus.corner_lr = '0;
		item_bus.corner_ul = '0;
		item_bus.corner_ur = '0;
		item_bus.query_x = '0;
		item_bus.query_y = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();

		// Reset values written back explicitly, then random traffic on the unit cell.
		configure(0, 0, INV_ONE, INV_ONE, 16, Q_ONE, Q_ONE);
		run_random(40);

		// Extreme origins and reciprocals push the normalized point into saturation; the
		// largest channel count must behave as the channel maximum.
		configure(Q_MAX, Q_MIN, Q_MAX, Q_MIN, 31, Q_ONE, Q_ONE);
		run_random(30);

		// Zero width reciprocal and a channel count of zero: queries return nothing.
		configure(Q_MIN, Q_MAX, 0, 1, 0, Q_ONE, Q_ONE);
		run_random(15);

		// Realistic cells: a single channel, then one past the maximum with a mirrored x
		// axis, then ordinary random counts.
		for (int p = 0; p < 5; p++) begin
			sx = $urandom_range(32'h4000, 32'h40_0000);
			sy = $urandom_range(32'h4000, 32'h40_0000);
			iw = inv_of(sx);
			case (p)
				0: chans = 1;
				1: begin
					chans = 17;
					iw = -iw;
				end
				default: chans = $urandom_range(1, BCI_MAX_CHANNELS);
			endcase
			configure(int'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000,
				int'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000, iw, inv_of(sy), chans,
				sx, sy);
			run_random(30);
		end

		settle();
		$display("Run covered %0d loads and %0d queries over %0d register settings.",
			checker_h.loads, checker_h.queries, settings_used + 1);
		$display("Checked %0d channel results: %0d mismatched, %0d unexpected, %0d missing.",
			checker_h.checked, checker_h.mismatches, checker_h.strays, checker_h.outstanding());
		if (checker_h.failures() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/bci_pkg.sv
hw/rtl/bci_intf.sv
hw/rtl/bci_ram.sv
hw/rtl/bci_ctrl.sv
hw/rtl/bci_datapath.sv
hw/rtl/bilinear_cell_interpolator.sv
hw/rtl/bci_checker.sv
bench/bilinear_cell_interpolator_test.sv
